@@ hdl/assert_macros.svh @@
// Assertion helpers for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TWD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TWD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/twd_pkg.sv @@
`default_nettype none

package twd_pkg;

    localparam int ID_W   = 16;
    localparam int KIND_W = 2;
    localparam int TASK_W = 4;
    localparam int UTIL_W = 16;
    localparam int TAB_W  = 64;

    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [1:0]        t_status;

    // Result status codes.
    localparam t_status ST_STORED   = 2'd0;
    localparam t_status ST_ASSIGNED = 2'd1;
    localparam t_status ST_NONE     = 2'd2;
    localparam t_status ST_DROPPED  = 2'd3;

    // Operation codes.
    localparam logic OP_ADD_WORKER = 1'b0;
    localparam logic OP_SUBMIT     = 1'b1;

    // Configuration register indexes.
    localparam logic REG_ABILITY = 1'b0;
    localparam logic REG_UTILITY = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [ID_W-1:0]   worker_id;
        t_kind             worker_kind;
        logic [TASK_W-1:0] task_kind;
    } t_item;

    typedef struct packed {
        t_status         status;
        logic [ID_W-1:0] assigned_id;
        t_kind           assigned_kind;
    } t_result;

    typedef struct packed {
        logic             index;
        logic [TAB_W-1:0] data;
    } t_cfg;

    typedef struct packed {
        logic clear;
        logic step;
    } t_scan_ctl;

    typedef struct packed {
        logic  found;
        t_kind kind;
    } t_best;

endpackage

`default_nettype wire

@@ hdl/twd_chan_if.sv @@
`default_nettype none

interface twd_chan_if
    import twd_pkg::*;
#(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hdl/twd_ram.sv @@
`default_nettype none

module twd_ram
    import twd_pkg::*;
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // The read data is held until the next read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hdl/twd_select.sv @@
`default_nettype none

module twd_select
    import twd_pkg::*;
#(
    parameter int CNT_W = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_scan_ctl         i_ctl,
    input  wire t_kind             i_kind,
    input  wire logic [UTIL_W-1:0] i_util,
    input  wire logic [CNT_W-1:0]  i_count,
    input  wire logic              i_elig,
    output t_best                  o_best
);

    localparam int PROD_W = UTIL_W + CNT_W;

    t_best              r_best;
    logic [UTIL_W-1:0]  r_best_u;
    logic [CNT_W-1:0]   r_best_c;
    logic [PROD_W-1:0]  cand_prod;
    logic [PROD_W-1:0]  best_prod;
    logic               better;

    // u/c < best_u/best_c is tested as u*best_c < best_u*c; a tie keeps the
    // earlier, lower-indexed type.
    always_comb begin
        cand_prod = PROD_W'(i_util) * PROD_W'(r_best_c);
        best_prod = PROD_W'(r_best_u) * PROD_W'(i_count);
        better    = i_elig && (!r_best.found || (cand_prod < best_prod));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= '0;
        end else if (i_ctl.clear) begin
            r_best <= '0;
        end else if (i_ctl.step && better) begin
            r_best.found <= 1'b1;
            r_best.kind  <= i_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step && better) begin
            r_best_u <= i_util;
            r_best_c <= i_count;
        end
    end

    assign o_best = r_best;

endmodule

`default_nettype wire

@@ hdl/typed_worker_dispatcher_unit.sv @@
// Typed worker dispatcher.
// Items arrive on i_item: an add-worker item pushes worker_id onto the free
// stack of its worker_kind, and a submit item picks the capable worker type
// with the least utility per free worker and pops that type's top worker.
// Each item produces exactly one result on o_result: a status, and for an
// assigned task the worker id and type.
// The two 64-bit tables are written through i_cfg, which is ready outside
// reset; writes are expected only while the block is idle.
// The worker ids live in one synchronous RAM of NUM_KINDS * STACK_DEPTH
// entries; the free counts are a small register file with one access port.
// An add-worker item stores its worker unless the stack is full or the type is
// out of range, and its result then goes to the output register. A submit item
// runs one scan step per type through a single comparator, a pop step that
// addresses the RAM and a step for the registered read that fills the output
// register; if no type qualifies, the pop step gives the result instead.
// One item is worked on at a time; i_item is ready whenever the engine is
// idle and out of reset, even while a result still waits in the output register.
// A stalled receiver holds the result, and a finished item waits in its last
// step until the output register is free. Reset clears the counts, tables and
// output valid; the RAM needs no clearing as entries are read only below the count.
`default_nettype none
`include "assert_macros.svh"

module typed_worker_dispatcher_unit
    import twd_pkg::*;
#(
    parameter int NUM_KINDS      = 4,
    parameter int NUM_TASK_KINDS = 16,
    parameter int STACK_DEPTH    = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    twd_chan_if.sink   i_item,
    twd_chan_if.source o_result,
    twd_chan_if.sink   i_cfg
);

    localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int KW        = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;
    localparam int MEM_DEPTH = NUM_KINDS * STACK_DEPTH;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    localparam logic [CNT_W-1:0]  DEPTH_C    = CNT_W'(STACK_DEPTH);
    localparam t_kind             LAST_KIND  = KIND_W'(NUM_KINDS - 1);
    localparam logic [TASK_W:0]   TASKS_C    = (TASK_W + 1)'(NUM_TASK_KINDS);
    localparam logic [KIND_W:0]   KINDS_C    = (KIND_W + 1)'(NUM_KINDS);

    // Engine states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADD  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_POP  = 3'd3;
    localparam logic [2:0] S_READ = 3'd4;

    logic [2:0]       r_state, n_state;
    t_item            r_item;
    t_kind            r_scan, n_scan;
    logic [CNT_W-1:0] r_count [NUM_KINDS];
    logic [TAB_W-1:0] r_abil;
    logic [TAB_W-1:0] r_util;
    logic             r_out_valid, n_out_valid;
    t_result          r_out, n_out;

    logic             item_acc;
    logic             out_free;
    logic [KW-1:0]    cidx;
    logic [CNT_W-1:0] cnt_rd;
    logic             cnt_we;
    logic [CNT_W-1:0] n_cnt;
    logic             kind_oob;
    logic             full;
    logic             task_ok;
    logic             ram_we;
    logic             ram_re;
    logic [AW-1:0]    ram_waddr;
    logic [AW-1:0]    ram_raddr;
    logic [ID_W-1:0]  ram_rdata;
    t_scan_ctl        scan_ctl;
    logic [UTIL_W-1:0] scan_util;
    logic             scan_elig;
    t_best            best;

    assign item_acc     = i_item.valid && i_item.ready;
    assign i_item.ready = i_rst_n && (r_state == S_IDLE);
    assign i_cfg.ready  = i_rst_n;
    assign out_free     = !r_out_valid || o_result.ready;

    // The count register file has a single access port, steered by state.
    always_comb begin
        case (r_state)
            S_ADD:   cidx = r_item.worker_kind[KW-1:0];
            S_SCAN:  cidx = r_scan[KW-1:0];
            S_POP:   cidx = best.kind[KW-1:0];
            default: cidx = '0;
        endcase
    end

    assign cnt_rd   = r_count[cidx];
    assign kind_oob = ({1'b0, r_item.worker_kind} >= KINDS_C);
    assign full     = kind_oob || (cnt_rd >= DEPTH_C);
    assign task_ok  = ({1'b0, r_item.task_kind} < TASKS_C);

    // Candidate of the current scan step.
    assign scan_util = r_util[r_scan * UTIL_W +: UTIL_W];
    assign scan_elig = task_ok && (cnt_rd != '0)
                       && r_abil[{r_scan, r_item.task_kind}];

    always_comb begin
        n_state     = r_state;
        n_scan      = r_scan;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out       = r_out;
        cnt_we      = 1'b0;
        n_cnt       = cnt_rd;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = AW'(cidx) * AW'(STACK_DEPTH) + AW'(cnt_rd);
        ram_raddr   = AW'(cidx) * AW'(STACK_DEPTH) + AW'(cnt_rd - 1'b1);
        scan_ctl    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (item_acc) begin
                    n_scan         = '0;
                    scan_ctl.clear = 1'b1;
                    n_state = (i_item.payload.operation == OP_SUBMIT) ? S_SCAN : S_ADD;
                end
            end
            S_ADD: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out         = '0;
                    n_out.status  = full ? ST_DROPPED : ST_STORED;
                    ram_we        = !full;
                    cnt_we        = !full;
                    n_cnt         = cnt_rd + 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_SCAN: begin
                scan_ctl.step = 1'b1;
                if (r_scan == LAST_KIND) begin
                    n_state = S_POP;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            S_POP: begin
                if (best.found) begin
                    // Pop: the new count addresses the top entry.
                    cnt_we  = 1'b1;
                    n_cnt   = cnt_rd - 1'b1;
                    ram_re  = 1'b1;
                    n_state = S_READ;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out        = '0;
                    n_out.status = ST_NONE;
                    n_state      = S_IDLE;
                end
            end
            S_READ: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.status        = ST_ASSIGNED;
                    n_out.assigned_id   = ram_rdata;
                    n_out.assigned_kind = best.kind;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_abil      <= '0;
            r_util      <= '0;
            for (int k = 0; k < NUM_KINDS; k++) begin
                r_count[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (cnt_we) begin
                r_count[cidx] <= n_cnt;
            end
            if (i_cfg.valid) begin
                unique case (i_cfg.payload.index)
                    REG_ABILITY: r_abil <= i_cfg.payload.data;
                    REG_UTILITY: r_util <= i_cfg.payload.data;
                    default:     r_abil <= r_abil;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_scan <= n_scan;
        if (item_acc) begin
            r_item <= i_item.payload;
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

    twd_ram #(
        .WIDTH (ID_W),
        .DEPTH (MEM_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_item.worker_id),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    twd_select #(
        .CNT_W (CNT_W)
    ) u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_kind  (r_scan),
        .i_util  (scan_util),
        .i_count (cnt_rd),
        .i_elig  (scan_elig),
        .o_best  (best)
    );

    // A chosen type must have a free worker to pop.
    `TWD_ASSERT_SAME(a_pop_nonempty, i_clk, i_rst_n, (r_state == S_POP) && best.found, cnt_rd != '0)
    // A count never exceeds the stack depth.
    `TWD_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, (r_state == S_ADD) && !kind_oob, cnt_rd <= DEPTH_C)
    // An accepted item always starts work in the next cycle.
    `TWD_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, item_acc, r_state != S_IDLE)
    // A finished read is delivered as an assignment.
    `TWD_ASSERT_NEXT(a_read_done, i_clk, i_rst_n, (r_state == S_READ) && out_free, r_out_valid && (r_out.status == ST_ASSIGNED))

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none

// Testbench for the typed worker dispatcher.
//
// Each item sent to the block either adds a free worker to the stack of its
// type or submits a job that takes a worker of the cheapest capable type.
// A predictor in this module keeps its own copy of the per-type stacks, the
// free counts and the two tables. It works out the one result that every
// accepted item must produce. The checker process compares each result that
// the block hands over against the oldest prediction still waiting.
//
// The run is a sequence of test tasks. A short directed part comes first:
// cleared tables after reset, zero utility and ties, a full stack, and the
// cross-multiplied utility-per-worker comparison. Random phases follow, each
// with its own table setting. Both sides of the item channels hold back at
// random, except in one phase in which neither side holds back.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import twd_pkg::*;

    localparam int KINDS          = 4;
    localparam int TASK_KINDS     = 16;
    localparam int DEPTH          = 16;
    localparam int SETTLE_CYCLES  = 12;
    localparam int IDLE_PERCENT   = 31;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 275;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    twd_chan_if #(.t_payload(t_item))   item_ch ();
    twd_chan_if #(.t_payload(t_result)) result_ch ();
    twd_chan_if #(.t_payload(t_cfg))    cfg_ch ();

    typed_worker_dispatcher_unit #(
        .NUM_KINDS      (KINDS),
        .NUM_TASK_KINDS (TASK_KINDS),
        .STACK_DEPTH    (DEPTH)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state: a mirror of the tables and of the worker stacks.
    logic [TAB_W-1:0] ability_model = '0;
    logic [TAB_W-1:0] utility_model = '0;
    logic [ID_W-1:0]  id_stack [KINDS][DEPTH];
    int unsigned      free_count [KINDS] = '{default: 0};

    t_result     awaited_results [$];
    int unsigned error_count = 0;
    // While this is set, neither side of the item channels holds back.
    bit          steady = 1'b0;

    // Works out the result of one accepted item and updates the mirror.
    // A submitted job goes to the capable, non-empty type whose utility per
    // free worker is least; the ratios are compared by cross-multiplication
    // and a tie keeps the lower type index.
    function automatic t_result predict_dispatch(input t_item it);
        t_result     res;
        bit          found;
        int unsigned pick;
        logic [63:0] pick_util;
        logic [63:0] pick_cnt;
        logic [63:0] util;
        logic [63:0] cnt;
        res = '0;
        if (it.operation == OP_ADD_WORKER) begin
            if (int'(it.worker_kind) >= KINDS || free_count[it.worker_kind] >= DEPTH) begin
                res.status = ST_DROPPED;
            end else begin
                id_stack[it.worker_kind][free_count[it.worker_kind]] = it.worker_id;
                free_count[it.worker_kind]++;
                res.status = ST_STORED;
            end
            return res;
        end
        found     = 1'b0;
        pick      = 0;
        pick_util = '0;
        pick_cnt  = 64'd1;
        if (int'(it.task_kind) < TASK_KINDS) begin
            for (int k = 0; k < KINDS; k++) begin
                if (free_count[k] != 0 && ability_model[(16 * k + int'(it.task_kind)) % 64]) begin
                    util = 64'(utility_model[16 * k +: 16]);
                    cnt  = 64'(free_count[k]);
                    if (!found || util * pick_cnt < pick_util * cnt) begin
                        found     = 1'b1;
                        pick      = k;
                        pick_util = util;
                        pick_cnt  = cnt;
                    end
                end
            end
        end
        if (!found) begin
            res.status = ST_NONE;
        end else begin
            free_count[pick]--;
            res.status        = ST_ASSIGNED;
            res.assigned_id   = id_stack[pick][free_count[pick]];
            res.assigned_kind = t_kind'(pick);
        end
        return res;
    endfunction

    function automatic t_item worker_item(input logic [ID_W-1:0] id, input t_kind kind);
        t_item it;
        it             = '0;
        it.operation   = OP_ADD_WORKER;
        it.worker_id   = id;
        it.worker_kind = kind;
        return it;
    endfunction

    function automatic t_item job_item(input logic [TASK_W-1:0] job_kind);
        t_item it;
        it           = '0;
        it.operation = OP_SUBMIT;
        it.task_kind = job_kind;
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t ns: %s, got %0h, expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Offers one item, sometimes after a short random gap, and records the
    // predicted result once the block has taken it. The valid line is left
    // high so that a following item can go out without a gap.
    task automatic send_item(input t_item it);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            gap = $urandom_range(3, 1);
        end
        if (gap != 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.payload <= it;
        do @(posedge i_clk); while (!item_ch.ready);
        awaited_results.insert(awaited_results.size(), predict_dispatch(it));
    endtask

    // Stops sending and waits until every predicted result has arrived, then
    // lets the pipeline settle so that the block is idle afterwards.
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [TAB_W-1:0] value);
        t_cfg word;
        word.index     = idx;
        word.data      = value;
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= word;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == REG_ABILITY) begin
            ability_model = value;
        end else begin
            utility_model = value;
        end
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // The receiving side stalls at random unless the steady flag is set.
    always @(posedge i_clk) begin
        result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Every result taken from the block must match the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result with nothing awaited, status",
                                32'(result_ch.payload.status), 32'(ST_NONE));
            end else begin
                want = awaited_results.pop_front();
                if (result_ch.payload.status !== want.status) begin
                    report_mismatch("status", 32'(result_ch.payload.status),
                                    32'(want.status));
                end
                if (result_ch.payload.assigned_id !== want.assigned_id) begin
                    report_mismatch("assigned_id", 32'(result_ch.payload.assigned_id),
                                    32'(want.assigned_id));
                end
                if (result_ch.payload.assigned_kind !== want.assigned_kind) begin
                    report_mismatch("assigned_kind", 32'(result_ch.payload.assigned_kind),
                                    32'(want.assigned_kind));
                end
            end
        end
    end

    // With both tables cleared by reset no type is capable of anything, so
    // every job finds no worker even when workers are free.
    task automatic test_cleared_tables();
        send_item(worker_item(16'h0000, t_kind'(0)));
        send_item(job_item(4'd0));
        send_item(job_item(4'd15));
    endtask

    // Zero utility is an ordinary value: equal ratios go to the lower type,
    // and a type with zero utility beats any type with a non-zero one.
    task automatic test_zero_utility();
        wait_idle();
        write_register(REG_ABILITY, '1);
        write_register(REG_UTILITY, '0);
        send_item(worker_item(16'hFFFF, t_kind'(3)));
        send_item(worker_item(16'h5A5A, t_kind'(2)));
        send_item(job_item(4'd15));
        send_item(job_item(4'd0));
        wait_idle();
        write_register(REG_UTILITY, 64'h0000_FFFF_FFFF_FFFF);
        send_item(worker_item(16'hA5A5, t_kind'(0)));
        send_item(job_item(4'd9));
        send_item(job_item(4'd9));
        send_item(job_item(4'd4));
    endtask

    // Sixteen workers fill the stack of type 1; the seventeenth is dropped.
    task automatic test_stack_full();
        for (int i = 0; i <= DEPTH; i++) begin
            send_item(worker_item(16'(i * 4099 + 17), t_kind'(1)));
        end
    endtask

    // Type 0 holds one worker at utility 2.0 and type 1 sixteen workers at
    // utility 3.0, so type 1 has the smaller share and must win the job.
    task automatic test_cross_product();
        wait_idle();
        write_register(REG_ABILITY, 64'h0000_0000_0040_0040);
        write_register(REG_UTILITY, 64'hFFFF_FFFF_0300_0200);
        send_item(worker_item(16'h1234, t_kind'(0)));
        send_item(job_item(4'd6));
        send_item(job_item(4'd5));
    endtask

    // Random phases, each with its own table setting and a chosen balance of
    // adds and jobs. Between phases the sender waits for all results, which
    // also makes room for the table writes.
    task automatic test_random_phases();
        t_item       it;
        int unsigned add_percent;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    write_register(REG_ABILITY, '1);
                    write_register(REG_UTILITY, '1);
                    add_percent = 50;
                end
                1: begin
                    write_register(REG_ABILITY, {$urandom, $urandom});
                    write_register(REG_UTILITY, '0);
                    add_percent = 50;
                end
                2: begin
                    // Small utilities make equal ratios, and so ties, common.
                    write_register(REG_ABILITY, {$urandom, $urandom} | {$urandom, $urandom});
                    write_register(REG_UTILITY, {16'($urandom_range(3) << 8),
                                                 16'($urandom_range(3) << 8),
                                                 16'($urandom_range(3) << 8),
                                                 16'($urandom_range(3) << 8)});
                    add_percent = 50;
                end
                3: begin
                    write_register(REG_ABILITY, {$urandom, $urandom});
                    write_register(REG_UTILITY, {$urandom, $urandom});
                    add_percent = 50;
                end
                4: begin
                    // Nothing is capable, so the stacks fill up and overflow.
                    write_register(REG_ABILITY, '0);
                    write_register(REG_UTILITY, {$urandom, $urandom});
                    add_percent = 60;
                end
                default: begin
                    write_register(REG_ABILITY, {$urandom, $urandom} | {$urandom, $urandom});
                    write_register(REG_UTILITY, {$urandom, $urandom});
                    add_percent = 35;
                end
            endcase
            steady = (phase == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                it.worker_id   = 16'($urandom);
                it.worker_kind = t_kind'($urandom_range(KINDS - 1));
                it.task_kind   = 4'($urandom_range(TASK_KINDS - 1));
                it.operation   = ($urandom_range(99) < add_percent) ? OP_ADD_WORKER
                                                                    : OP_SUBMIT;
                send_item(it);
            end
            steady = 1'b0;
        end
    endtask

    initial begin
        item_ch.valid     = 1'b0;
        item_ch.payload   = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.payload    = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_cleared_tables();
        test_zero_utility();
        test_stack_full();
        test_cross_product();
        test_random_phases();

        wait_idle();
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Guard against a hang: the slowest correct run is far shorter than this.
    initial begin
        #10ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
